FILE: hdl/hcbd_pkg.sv
// shared types, constants and character helpers for the chunked body decoder
`timescale 1ns / 1ps

package hcbd_pkg;

    // longest size line, CR and LF not counted
    localparam logic [3:0] MAX_LINE_CHARS = 4'd8;

    // characters of the framing
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_VT  = 8'h0B;
    localparam logic [7:0] CHAR_FF  = 8'h0C;

    // result kinds
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // size value that marks saturation
    localparam logic [31:0] SIZE_SAT = 32'hFFFF_FFFF;

    typedef enum logic [6:0] {
        PH_LEAD   = 7'b0000001,
        PH_DIGITS = 7'b0000010,
        PH_DATA   = 7'b0000100,
        PH_CR     = 7'b0001000,
        PH_LF     = 7'b0010000,
        PH_END    = 7'b0100000,
        PH_ERR    = 7'b1000000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] size_value;
        logic [3:0]  line_chars;
        logic        digits_ended;
        logic [31:0] bytes_left;
    } state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
        logic       chunk_last;
    } result_t;

    // true for a hex digit character
    function automatic logic hex_valid(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    // value of a hex digit character
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        else
        begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    // leading white space of a size line
    function automatic logic is_blank(input logic [7:0] c);
        return c == CHAR_SP || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF;
    endfunction

endpackage

FILE: hdl/hcbd_byte_if.sv
// valid/ready channel that carries one raw body byte
`timescale 1ns / 1ps

interface hcbd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: hdl/hcbd_result_if.sv
// valid/ready channel that carries one decoder result
`timescale 1ns / 1ps

interface hcbd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload;
    logic       chunk_last;

    modport source (output valid, output kind, output payload, output chunk_last, input ready);
    modport sink   (input valid, input kind, input payload, input chunk_last, output ready);
endinterface

FILE: hdl/hcbd_step.sv
// next-state and result logic for one body byte
`timescale 1ns / 1ps

module hcbd_step (
    input  hcbd_pkg::state_t  state,
    input  logic [7:0]        in_byte,
    output hcbd_pkg::state_t  state_next,
    output hcbd_pkg::result_t result
);

    logic [31:0] left_dec;

    // remaining count after this payload byte
    assign left_dec = (state.bytes_left != 32'd0) ? state.bytes_left - 32'd1 : 32'd0;

    always_comb
    begin
        state_next        = state;
        result.kind       = hcbd_pkg::KIND_FRAME;
        result.payload    = 8'd0;
        result.chunk_last = 1'b0;

        unique case (state.phase) inside
            hcbd_pkg::PH_LEAD,
            hcbd_pkg::PH_DIGITS:
            begin
                if (in_byte == hcbd_pkg::CHAR_CR)
                begin
                    // dropped
                end
                else if (in_byte == hcbd_pkg::CHAR_LF)
                begin
                    state_next.line_chars   = 4'd0;
                    state_next.digits_ended = 1'b0;
                    if (state.size_value == 32'd0)
                    begin
                        state_next.phase = hcbd_pkg::PH_END;
                        result.kind      = hcbd_pkg::KIND_END;
                    end
                    else
                    begin
                        state_next.bytes_left = state.size_value;
                        state_next.phase      = hcbd_pkg::PH_DATA;
                    end
                end
                else if (state.line_chars >= hcbd_pkg::MAX_LINE_CHARS)
                begin
                    state_next.phase = hcbd_pkg::PH_ERR;
                    result.kind      = hcbd_pkg::KIND_ERR;
                end
                else
                begin
                    state_next.line_chars = state.line_chars + 4'd1;
                    if (!state.digits_ended)
                    begin
                        if (hcbd_pkg::hex_valid(in_byte))
                        begin
                            // shift in a digit, saturate on overflow
                            if (state.size_value[31:28] != 4'd0)
                            begin
                                state_next.size_value = hcbd_pkg::SIZE_SAT;
                            end
                            else
                            begin
                                state_next.size_value = {state.size_value[27:0],
                                                         hcbd_pkg::hex_digit(in_byte)};
                            end
                            state_next.phase = hcbd_pkg::PH_DIGITS;
                        end
                        else if (!(state.phase == hcbd_pkg::PH_LEAD &&
                                   hcbd_pkg::is_blank(in_byte)))
                        begin
                            state_next.digits_ended = 1'b1;
                        end
                    end
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                result.kind           = hcbd_pkg::KIND_DATA;
                result.payload        = in_byte;
                state_next.bytes_left = left_dec;
                if (left_dec == 32'd0)
                begin
                    result.chunk_last = 1'b1;
                    state_next.phase  = hcbd_pkg::PH_CR;
                end
            end
            hcbd_pkg::PH_CR:
            begin
                if (in_byte == hcbd_pkg::CHAR_CR)
                begin
                    state_next.phase = hcbd_pkg::PH_LF;
                end
                else
                begin
                    state_next.phase = hcbd_pkg::PH_ERR;
                    result.kind      = hcbd_pkg::KIND_ERR;
                end
            end
            hcbd_pkg::PH_LF:
            begin
                if (in_byte == hcbd_pkg::CHAR_LF)
                begin
                    // open the next size line
                    state_next.phase        = hcbd_pkg::PH_LEAD;
                    state_next.size_value   = 32'd0;
                    state_next.line_chars   = 4'd0;
                    state_next.digits_ended = 1'b0;
                end
                else
                begin
                    state_next.phase = hcbd_pkg::PH_ERR;
                    result.kind      = hcbd_pkg::KIND_ERR;
                end
            end
            hcbd_pkg::PH_END:
            begin
                result.kind = hcbd_pkg::KIND_END;
            end
            default:
            begin
                state_next.phase = hcbd_pkg::PH_ERR;
                result.kind      = hcbd_pkg::KIND_ERR;
            end
        endcase
    end

endmodule

FILE: hdl/http_chunked_body_decoder.sv
// HTTP chunked body decoder: one raw byte in, one result out per transfer
// output: a result is registered and offered in the cycle after its byte transfer
// throughput: one byte per cycle unless result.ready stalls; results free as taken
// the decoder state registers close the only loop, updated once per byte
// reset: asynchronous, active low; clears the decoder to the first size line
// and empties the result register; no clearing pass
`timescale 1ns / 1ps

module http_chunked_body_decoder (
    input  logic           clk,
    input  logic           rst_n,
    hcbd_byte_if.sink      body,
    hcbd_result_if.source  result
);

    hcbd_pkg::state_t  state_reg;
    hcbd_pkg::state_t  state_next;
    hcbd_pkg::result_t res_reg;
    hcbd_pkg::result_t res_next;
    logic              out_valid_reg;
    logic              take;

    // accept while the result register is empty or being drained
    assign body.ready = !out_valid_reg || result.ready;
    assign take       = body.valid && body.ready;

    hcbd_step u_step (
        .state      (state_reg),
        .in_byte    (body.in_byte),
        .state_next (state_next),
        .result     (res_next)
    );

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= hcbd_pkg::PH_LEAD;
            state_reg.size_value   <= 32'd0;
            state_reg.line_chars   <= 4'd0;
            state_reg.digits_ended <= 1'b0;
            state_reg.bytes_left   <= 32'd0;
        end
        else if (take)
        begin
            state_reg <= state_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.kind       = res_reg.kind;
    assign result.payload    = res_reg.payload;
    assign result.chunk_last = res_reg.chunk_last;

endmodule
